/* src/mpoc_pkg.sv */
// Package for the multi-phrase occurrence counter.
// Holds the shared widths, register indexes, reset values and types.
// No dependencies.
package mpoc_pkg;

    localparam int SLOTS = 4;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 4;
    localparam int POS_W = 3;
    localparam int TEXT_W = 64;
    localparam int LENS_W = SLOTS * LEN_W;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_MAX_PHRASES = 4;
    localparam int DEF_MAX_PHRASE_LEN = 8;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [TEXT_W-1:0] RST_PHRASE_A = 64'h0000_0052_4F52_5245;
    localparam logic [TEXT_W-1:0] RST_PHRASE_B = 64'h0047_4E49_4E52_4157;
    localparam logic [TEXT_W-1:0] RST_PHRASE_C = 64'h0000_0000_4F46_4E49;
    localparam logic [TEXT_W-1:0] RST_PHRASE_D = 64'h0000_0000_0000_0000;
    localparam logic [LENS_W-1:0] RST_LENGTHS = 16'h0475;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHRASE_A = 3'd0,
        CFG_PHRASE_B = 3'd1,
        CFG_PHRASE_C = 3'd2,
        CFG_PHRASE_D = 3'd3,
        CFG_LENGTHS  = 3'd4
    } cfg_reg_t;

    typedef logic [SLOTS-1:0][BYTE_W-1:0] slot_bytes_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } hist_ctl_t;

endpackage

/* src/mpoc_hist_cell.sv */
// One history cell: holds one past byte of the current file and its valid bit.
// Compares the byte against the expected phrase byte of every slot.
// Depends on mpoc_pkg.
module mpoc_hist_cell
    import mpoc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  hist_ctl_t         ctl,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              valid_in,
    input  slot_bytes_t       want,
    input  logic [SLOTS-1:0]  care,
    output logic [BYTE_W-1:0] byte_out,
    output logic              valid_out,
    output logic [SLOTS-1:0]  ok
);

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            byte_reg <= byte_in;
        end
    end

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            ok[k] = !care[k] || (valid_reg && (byte_reg == want[k]));
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* src/mpoc_tally.sv */
// Saturating occurrence counter for one phrase.
// Presents the low bits of the count as the result total.
// Depends on mpoc_pkg.
module mpoc_tally
    import mpoc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               inc,
    output logic [TOTAL_W-1:0] total
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (inc && (count_reg != '1)) begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign total = TOTAL_W'(count_reg);

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !inc |=> $stable(count_reg))
        else $error("count changed without a hit");

    a_step_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (inc && (count_reg != '1)) |=> (count_reg == $past(count_reg) + COUNT_WIDTH'(1)))
        else $error("count did not advance by one on a hit");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '1) |=> (count_reg == '1))
        else $error("saturated count wrapped");

endmodule

/* src/multi_phrase_occurrence_counter_unit.sv */
// Top level of the multi-phrase occurrence counter.
// Depends on mpoc_pkg, mpoc_hist_cell and mpoc_tally.
//
// Each input word carries one text byte and an end-of-file flag. Each accepted
// word produces exactly one output word: a mask of the phrases that end on
// this byte and the four running totals after it, registered and shown in the
// cycle after acceptance. One word per cycle is sustained unless m_ready
// stalls; the window is a row of shift cells, all phrases compared in parallel.
// An output register separates the channels: s_ready stays high while the
// output is empty or being taken, and drops only while a result waits on a
// stalled receiver. After the last byte of a file the window is cleared, so
// no match crosses files; the totals are kept until reset.
// Phrase texts and lengths are written via cfg_wr_en, cfg_index and cfg_wdata;
// the user must do so only while idle; the block does not enforce it. Reset
// loads the default phrases, empties the window, clears totals and m_valid.
module multi_phrase_occurrence_counter_unit
    import mpoc_pkg::*;
#(
    parameter int MAX_PHRASES    = DEF_MAX_PHRASES,
    parameter int MAX_PHRASE_LEN = DEF_MAX_PHRASE_LEN,
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_text_byte,
    input  logic                  s_end_of_file,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOTS-1:0]      m_hit_mask,
    output logic [TOTAL_W-1:0]    m_total_a,
    output logic [TOTAL_W-1:0]    m_total_b,
    output logic [TOTAL_W-1:0]    m_total_c,
    output logic [TOTAL_W-1:0]    m_total_d,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HIST_DEPTH = MAX_PHRASE_LEN - 1;

    logic [SLOTS-1:0][TEXT_W-1:0] phrase_text_reg;
    logic [LENS_W-1:0]            phrase_lengths_reg;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [SLOTS-1:0]             hit_mask_reg;

    logic                         s_fire;
    hist_ctl_t                    hist_ctl;

    logic [HIST_DEPTH-1:0][BYTE_W-1:0] cell_byte;
    logic [HIST_DEPTH-1:0]             cell_valid;
    logic [HIST_DEPTH-1:0][SLOTS-1:0]  cell_ok;
    logic [HIST_DEPTH-1:0][SLOTS-1:0]  cell_care;
    slot_bytes_t [HIST_DEPTH-1:0]      cell_want;

    logic [SLOTS-1:0]              slot_enabled;
    logic [SLOTS-1:0]              cur_eq;
    logic [SLOTS-1:0]              all_ok;
    logic [SLOTS-1:0]              hit;
    logic [SLOTS-1:0][TOTAL_W-1:0] tally_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phrase_text_reg[0] <= RST_PHRASE_A;
            phrase_text_reg[1] <= RST_PHRASE_B;
            phrase_text_reg[2] <= RST_PHRASE_C;
            phrase_text_reg[3] <= RST_PHRASE_D;
            phrase_lengths_reg <= RST_LENGTHS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PHRASE_A: begin
                    phrase_text_reg[0] <= cfg_wdata;
                end
                CFG_PHRASE_B: begin
                    phrase_text_reg[1] <= cfg_wdata;
                end
                CFG_PHRASE_C: begin
                    phrase_text_reg[2] <= cfg_wdata;
                end
                CFG_PHRASE_D: begin
                    phrase_text_reg[3] <= cfg_wdata;
                end
                CFG_LENGTHS: begin
                    phrase_lengths_reg <= cfg_wdata[LENS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready        = !m_valid_reg || m_ready;
    assign s_fire         = s_valid && s_ready;
    assign hist_ctl.shift = s_fire && !s_end_of_file;
    assign hist_ctl.clear = s_fire && s_end_of_file;

    always_comb begin
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        for (int k = 0; k < SLOTS; k++) begin
            len = phrase_lengths_reg[k*LEN_W +: LEN_W];
            slot_enabled[k] = (len != '0) && (len <= LEN_W'(MAX_PHRASE_LEN))
                              && (k < MAX_PHRASES);
            pos = POS_W'(len - LEN_W'(1));
            cur_eq[k] = (s_text_byte == phrase_text_reg[k][pos*BYTE_W +: BYTE_W]);
            for (int j = 0; j < HIST_DEPTH; j++) begin
                cell_care[j][k] = (len >= LEN_W'(j + 2));
                pos = POS_W'(len - LEN_W'(j + 2));
                cell_want[j][k] = phrase_text_reg[k][pos*BYTE_W +: BYTE_W];
            end
        end
    end

    for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_cell
        logic [BYTE_W-1:0] byte_in;
        logic              valid_in;

        if (j == 0) begin : g_head
            assign byte_in  = s_text_byte;
            assign valid_in = 1'b1;
        end else begin : g_link
            assign byte_in  = cell_byte[j-1];
            assign valid_in = cell_valid[j-1];
        end

        mpoc_hist_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (hist_ctl),
            .byte_in   (byte_in),
            .valid_in  (valid_in),
            .want      (cell_want[j]),
            .care      (cell_care[j]),
            .byte_out  (cell_byte[j]),
            .valid_out (cell_valid[j]),
            .ok        (cell_ok[j])
        );
    end

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            all_ok[k] = 1'b1;
            for (int j = 0; j < HIST_DEPTH; j++) begin
                all_ok[k] = all_ok[k] && cell_ok[j][k];
            end
            hit[k] = slot_enabled[k] && cur_eq[k] && all_ok[k];
        end
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_tally
        mpoc_tally #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_tally (
            .aclk    (aclk),
            .aresetn (aresetn),
            .inc     (s_fire && hit[k]),
            .total   (tally_total[k])
        );
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hit_mask_reg <= hit;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit_mask = hit_mask_reg;
    assign m_total_a  = tally_total[0];
    assign m_total_b  = tally_total[1];
    assign m_total_c  = tally_total[2];
    assign m_total_d  = tally_total[3];

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while a result is stalled");

    a_window_fills_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("history valid bits are not contiguous");

    a_hits_only_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (hit_mask_reg & ~$past(slot_enabled)) == '0)
        else $error("hit reported for a disabled phrase");

endmodule

/* verif/multi_phrase_occurrence_counter_unit_tb.sv */
// Self-checking testbench for multi_phrase_occurrence_counter_unit: a scoreboard
// predicts the hit mask and the four totals of every text word and checks each output word.
// Depends on mpoc_pkg and the RTL of the block.
module multi_phrase_occurrence_counter_unit_tb;
    import mpoc_pkg::*;

    localparam int HIST_DEPTH = DEF_MAX_PHRASE_LEN - 1;
    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_WORDS = 155;
    localparam int EOF_PCT = 4;

    typedef enum {LENS_LONGEST, LENS_SHORTEST, LENS_DISABLED_MIX, LENS_RANDOM} lens_mode_t;

    typedef struct packed {
        logic [SLOTS-1:0]              hit_mask;
        logic [SLOTS-1:0][TOTAL_W-1:0] totals;
    } count_word_t;

    class phrase_count_scoreboard;
        logic [TEXT_W-1:0]             phrase_text [SLOTS];
        logic [LENS_W-1:0]             phrase_lens;
        logic [BYTE_W-1:0]             recent [HIST_DEPTH];
        int                            fill;
        logic [SLOTS-1:0][TOTAL_W-1:0] totals;
        count_word_t                   expected_words [$];
        int                            words_in;
        int                            words_out;
        int                            files_seen;
        int                            errors;

        function new();
            phrase_text = '{RST_PHRASE_A, RST_PHRASE_B, RST_PHRASE_C, RST_PHRASE_D};
            phrase_lens = RST_LENGTHS;
            foreach (recent[i]) recent[i] = '0;
            fill = 0;
            totals = '0;
            words_in = 0;
            words_out = 0;
            files_seen = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PHRASE_A, CFG_PHRASE_B, CFG_PHRASE_C, CFG_PHRASE_D: begin
                    phrase_text[idx] = value;
                end
                CFG_LENGTHS: begin
                    phrase_lens = value[LENS_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function bit phrase_ends_here(int slot, logic [BYTE_W-1:0] cur);
            int                len;
            logic [BYTE_W-1:0] got;
            len = phrase_lens[slot*LEN_W +: LEN_W];
            if (slot >= DEF_MAX_PHRASES || len == 0 || len > DEF_MAX_PHRASE_LEN) return 0;
            if (fill + 1 < len) return 0;
            for (int i = 0; i < len; i++) begin
                got = (i == 0) ? cur : recent[i-1];
                if (phrase_text[slot][BYTE_W*(len-1-i) +: BYTE_W] !== got) return 0;
            end
            return 1;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] text_byte, logic end_of_file);
            count_word_t w;
            w.hit_mask = '0;
            for (int k = 0; k < SLOTS; k++) begin
                if (phrase_ends_here(k, text_byte)) begin
                    w.hit_mask[k] = 1'b1;
                    if (totals[k] != '1) totals[k] = totals[k] + 1'b1;
                end
            end
            // The history is updated only after all phrases saw this byte.
            if (end_of_file) begin
                foreach (recent[i]) recent[i] = '0;
                fill = 0;
                files_seen++;
            end else begin
                for (int i = HIST_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
                recent[0] = text_byte;
                if (fill < HIST_DEPTH) fill++;
            end
            w.totals = totals;
            expected_words.insert(expected_words.size(), w);
            words_in++;
        endfunction

        task report(string msg);
            if (errors < 40) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(logic [SLOTS-1:0] mask, logic [SLOTS-1:0][TOTAL_W-1:0] got_totals);
            count_word_t want;
            words_out++;
            if (expected_words.size() == 0) begin
                report($sformatf("output word %0d arrived with nothing expected", words_out));
                return;
            end
            want = expected_words.pop_front();
            if (mask !== want.hit_mask)
                report($sformatf("output word %0d: hit mask %h, expected %h",
                                 words_out, mask, want.hit_mask));
            for (int k = 0; k < SLOTS; k++) begin
                if (got_totals[k] !== want.totals[k])
                    report($sformatf("output word %0d: total %0d is %0d, expected %0d",
                                     words_out, k, got_totals[k], want.totals[k]));
            end
        endtask

        task close_out();
            if (expected_words.size() != 0)
                report($sformatf("%0d expected words never came out", expected_words.size()));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_text_byte = '0;
    logic                  s_end_of_file = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SLOTS-1:0]      m_hit_mask;
    logic [TOTAL_W-1:0]    m_total_a;
    logic [TOTAL_W-1:0]    m_total_b;
    logic [TOTAL_W-1:0]    m_total_c;
    logic [TOTAL_W-1:0]    m_total_d;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    phrase_count_scoreboard tally = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_at_word = -1;
    int hold_left = 0;
    int quiet_cycles = 0;
    int settings_used = 1;

    multi_phrase_occurrence_counter_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_file (s_end_of_file),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_mask    (m_hit_mask),
        .m_total_a     (m_total_a),
        .m_total_b     (m_total_b),
        .m_total_c     (m_total_c),
        .m_total_d     (m_total_d),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The receiver stalls at random, or holds off for a long stretch once a set word
    // count has gone in, so that the output register fills and the input stalls.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (tally.words_in == hold_at_word) begin
            m_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_at_word = -1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tally.check_word(m_hit_mask, {m_total_d, m_total_c, m_total_b, m_total_a});
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stalled for %0d cycles with %0d words outstanding",
                     quiet_cycles, tally.expected_words.size());
            $display("multi_phrase_occurrence_counter_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] text_byte, input logic end_of_file);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= text_byte;
        s_end_of_file <= end_of_file;
        do @(posedge aclk); while (!s_ready);
        tally.note_byte(text_byte, end_of_file);
        @(negedge aclk);
    endtask

    task automatic send_text(input string s, input bit eof_last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], eof_last && (i == s.len() - 1));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tally.expected_words.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // Writes all five registers, then one random index past the last, which must be ignored.
    task automatic program_phrases(input logic [TEXT_W-1:0] a, input logic [TEXT_W-1:0] b,
                                   input logic [TEXT_W-1:0] c, input logic [TEXT_W-1:0] d,
                                   input logic [LENS_W-1:0] lens);
        logic [CFG_DATA_W-1:0] vals [CFG_LENGTHS+1];
        logic [CFG_IDX_W-1:0]  stray;
        vals[CFG_PHRASE_A] = a;
        vals[CFG_PHRASE_B] = b;
        vals[CFG_PHRASE_C] = c;
        vals[CFG_PHRASE_D] = d;
        vals[CFG_LENGTHS] = CFG_DATA_W'(lens);
        for (int r = CFG_PHRASE_A; r <= CFG_LENGTHS; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_wdata <= vals[r];
            tally.set_reg(CFG_IDX_W'(r), vals[r]);
            @(negedge aclk);
        end
        stray = CFG_IDX_W'($urandom_range(CFG_LENGTHS + 1, 2**CFG_IDX_W - 1));
        cfg_index <= stray;
        cfg_wdata <= {$urandom, $urandom};
        tally.set_reg(stray, '0);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    task automatic run_phase(input lens_mode_t mode, input int tx_idle, input int rx_stall,
                             input bit long_hold, input bit mid_pause);
        logic [BYTE_W-1:0] alpha [3];
        logic [TEXT_W-1:0] txt [SLOTS];
        logic [LENS_W-1:0] lens;
        int                len;
        int                slot;
        int                n;
        int                pick;
        bit                paused;
        foreach (alpha[i]) alpha[i] = BYTE_W'($urandom_range(255));
        for (int s = 0; s < SLOTS; s++) begin
            case (mode)
                LENS_LONGEST:  len = DEF_MAX_PHRASE_LEN;
                LENS_SHORTEST: len = 1;
                LENS_DISABLED_MIX: begin
                    case ($urandom_range(3))
                        0:       len = 0;
                        1:       len = $urandom_range(DEF_MAX_PHRASE_LEN + 1, 2**LEN_W - 1);
                        default: len = $urandom_range(1, DEF_MAX_PHRASE_LEN);
                    endcase
                end
                default: begin
                    len = ($urandom_range(9) == 0) ?
                          $urandom_range(DEF_MAX_PHRASE_LEN + 1, 2**LEN_W - 1) :
                          $urandom_range(1, DEF_MAX_PHRASE_LEN);
                end
            endcase
            txt[s] = {$urandom, $urandom};
            for (int i = 0; i < len && i < DEF_MAX_PHRASE_LEN; i++)
                txt[s][BYTE_W*i +: BYTE_W] = alpha[$urandom_range(2)];
            lens[LEN_W*s +: LEN_W] = LEN_W'(len);
        end
        program_phrases(txt[0], txt[1], txt[2], txt[3], lens);
        tx_idle_pct = tx_idle;
        rx_stall_pct = rx_stall;
        if (long_hold) hold_at_word = tally.words_in + 40;
        n = 0;
        paused = 0;
        while (n < PHASE_WORDS) begin
            if (mid_pause && !paused && n >= PHASE_WORDS / 2) begin
                drain();
                paused = 1;
            end
            pick = $urandom_range(99);
            if (pick < 25) begin
                // Whole phrases with random file breaks give deep, overlapping matches.
                slot = $urandom_range(SLOTS - 1);
                len = lens[LEN_W*slot +: LEN_W];
                if (len == 0 || len > DEF_MAX_PHRASE_LEN)
                    len = $urandom_range(1, DEF_MAX_PHRASE_LEN);
                for (int i = 0; i < len; i++)
                    send_word(txt[slot][BYTE_W*i +: BYTE_W], $urandom_range(99) < EOF_PCT);
                n += len;
            end else if (pick < 35) begin
                send_word(BYTE_W'($urandom_range(255)), $urandom_range(99) < EOF_PCT);
                n++;
            end else begin
                send_word(alpha[$urandom_range(2)], $urandom_range(99) < EOF_PCT);
                n++;
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default phrases, a match on the last byte of a file, and a phrase split by a file end.
        send_text("WARNINGERROR", 1);
        send_text("INF", 1);
        send_text("O", 0);
        drain();

        // Longest phrase with overlap, a one-byte phrase with junk above it, and lengths
        // nine and fifteen that must stay disabled.
        program_phrases(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 16'hF918);
        send_word(8'h00, 1'b0);
        for (int i = 0; i < 9; i++) send_word(8'hFF, i == 8);
        drain();

        run_phase(LENS_LONGEST, 0, 0, 1, 0);
        run_phase(LENS_SHORTEST, 48, 0, 0, 1);
        run_phase(LENS_DISABLED_MIX, 0, 48, 0, 0);
        run_phase(LENS_RANDOM, 15, 15, 0, 0);
        run_phase(LENS_RANDOM, 0, 0, 0, 0);
        run_phase(LENS_DISABLED_MIX, 15, 15, 0, 0);
        repeat (4) @(negedge aclk);

        tally.close_out();
        $display("Checked %0d text words in %0d files under %0d phrase settings.",
                 tally.words_in, tally.files_seen, settings_used);
        $display("Phrase totals at the end: %0d %0d %0d %0d; %0d mismatches.",
                 tally.totals[0], tally.totals[1], tally.totals[2], tally.totals[3],
                 tally.errors);
        if (tally.errors == 0) begin
            $display("multi_phrase_occurrence_counter_unit regression: pass");
        end else begin
            $display("multi_phrase_occurrence_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
